// ===== rtl/core/rtcp_compound_parser_assert.svh =====
// ----------------------------------------------------------------------------
// RTCP compound parser assertion macros
// Shared concurrent assertion forms, clocked on the rising edge, off in reset.
// ----------------------------------------------------------------------------
`ifndef RTCP_COMPOUND_PARSER_ASSERT_SVH
`define RTCP_COMPOUND_PARSER_ASSERT_SVH

// General property, checked on every edge out of reset
`define RTCP_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Condition that must never be seen
`define RTCP_NEVER(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error(msg);

`endif

// ===== rtl/core/rtcp_pkg.sv =====
// ----------------------------------------------------------------------------
// RTCP compound parser package
// Transaction types, record and status codes, RTCP constants, queue sizing.
// ----------------------------------------------------------------------------
package rtcp_pkg;

    typedef struct packed {
        logic [7:0]  data_byte;
        logic        start_req;
        logic [15:0] compound_length;
    } rtcp_in_t;

    typedef struct packed {
        logic [2:0]         record_kind;
        logic [2:0]         status;
        logic [31:0]        ssrc_a;
        logic [31:0]        ssrc_b;
        logic [63:0]        ntp_stamp;
        logic [31:0]        word_a;
        logic [31:0]        word_b;
        logic [31:0]        word_c;
        logic [31:0]        word_d;
        logic [7:0]         frac_lost;
        logic signed [23:0] cum_lost;
        logic               last;
    } rtcp_rec_t;

    // Up to two records leave the parser per byte
    typedef struct packed {
        logic      push0;
        logic      push1;
        rtcp_rec_t rec0;
        rtcp_rec_t rec1;
    } rtcp_push_t;

    typedef enum logic [2:0] {
        MODE_HDR,
        MODE_SR,
        MODE_RR,
        MODE_NACK,
        MODE_PLI,
        MODE_SKIP
    } rtcp_mode_t;

    localparam logic [2:0] KIND_SR        = 3'd0;
    localparam logic [2:0] KIND_RR_HDR    = 3'd1;
    localparam logic [2:0] KIND_RR_BLOCK  = 3'd2;
    localparam logic [2:0] KIND_NACK_HDR  = 3'd3;
    localparam logic [2:0] KIND_NACK_ITEM = 3'd4;
    localparam logic [2:0] KIND_PLI       = 3'd5;
    localparam logic [2:0] KIND_STATUS    = 3'd6;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_BAD_VER   = 3'd1;
    localparam logic [2:0] ST_OVERRUN   = 3'd2;
    localparam logic [2:0] ST_TOO_SHORT = 3'd3;
    localparam logic [2:0] ST_TRAILING  = 3'd4;

    localparam logic [7:0] PT_SR   = 8'd200;
    localparam logic [7:0] PT_RR   = 8'd201;
    localparam logic [7:0] PT_RTPFB = 8'd205;
    localparam logic [7:0] PT_PSFB = 8'd206;

    localparam logic [1:0] RTP_VERSION = 2'd2;
    localparam logic [4:0] FMT_ONE     = 5'd1;

    localparam int HDR_BYTES    = 4;
    localparam int SR_MIN_BYTES = 28;
    localparam int FB_MIN_BYTES = 12;
    localparam int RR_HDR_BYTES = 8;
    localparam int BLOCK_BYTES  = 24;

    localparam int Q_DEPTH = 4;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

endpackage

// ===== rtl/core/rtcp_out_queue.sv =====
// ----------------------------------------------------------------------------
// RTCP record queue
// Small record FIFO; takes one or two records a cycle, hands out one.
// ----------------------------------------------------------------------------
`include "rtcp_compound_parser_assert.svh"

module rtcp_out_queue
    import rtcp_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  rtcp_push_t push,
    output logic       space_ok,
    output logic       rec_valid,
    input  logic       rec_ready,
    output rtcp_rec_t  rec_data
);

    rtcp_rec_t            mem [Q_DEPTH];
    logic [Q_PTR_W-1:0]   head_reg, head_next;
    logic [Q_PTR_W-1:0]   tail_reg, tail_next;
    logic [Q_CNT_W-1:0]   count_reg, count_next;
    logic                 pop;
    logic [Q_CNT_W-1:0]   n_push;

    assign pop       = rec_valid && rec_ready;
    assign rec_valid = (count_reg != '0);
    assign rec_data  = mem[head_reg];
    assign space_ok  = (count_reg <= Q_CNT_W'(Q_DEPTH - 2));

    always_comb
    begin
        n_push     = Q_CNT_W'(push.push0) + Q_CNT_W'(push.push1);
        tail_next  = tail_reg + Q_PTR_W'(n_push);
        head_next  = pop ? head_reg + 1'b1 : head_reg;
        count_next = count_reg + n_push - Q_CNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push.push0)
        begin
            mem[tail_reg] <= push.rec0;
        end
        if (push.push1)
        begin
            mem[tail_reg + 1'b1] <= push.rec1;
        end
    end

    `RTCP_NEVER(a_q_bound, clk, rst_n, count_reg > Q_CNT_W'(Q_DEPTH), "queue count past depth")
    `RTCP_NEVER(a_q_room, clk, rst_n, push.push0 && !space_ok, "record pushed without room")
    `RTCP_ASSERT(a_q_pop, clk, rst_n, (pop && !push.push0) |=> (count_reg == $past(count_reg) - 1'b1), "pop did not drain")

endmodule

// ===== rtl/core/rtcp_parse_core.sv =====
// ----------------------------------------------------------------------------
// RTCP parse core
// Walks headers and packet bodies one byte a cycle while accept is high, forms result records.
// ----------------------------------------------------------------------------
`include "rtcp_compound_parser_assert.svh"

module rtcp_parse_core
    import rtcp_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       accept,
    input  rtcp_in_t   in_data,
    output rtcp_push_t push
);

    logic [15:0] co_reg, co_next;
    logic [15:0] po_reg, po_next;
    logic [15:0] ps_reg, ps_next;
    rtcp_mode_t  mode_reg, mode_next;
    logic [4:0]  count_reg, count_next;
    logic [4:0]  blocks_reg, blocks_next;
    logic [4:0]  phase_reg, phase_next;
    logic [31:0] aw_reg, aw_next;
    logic        drop_reg, drop_next;

    logic [31:0] ssrc_reg, ssrc_next;
    logic [63:0] ntp_reg, ntp_next;
    logic [31:0] hw_reg [4];
    logic [31:0] hw_next [4];

    // values after an optional restart
    logic [15:0] co, po, ps, len, co_inc;
    rtcp_mode_t  mode;
    logic [4:0]  blocks;
    logic [31:0] aw, aw_n;
    logic        drop, active;

    logic [7:0]  pt;
    logic [16:0] pkt_words;
    logic [18:0] pkt;
    logic [15:0] pkt_start;
    logic [19:0] pkt_end;
    logic [9:0]  min_bytes;
    rtcp_mode_t  new_mode;
    logic        fail;
    logic [2:0]  fail_code;
    logic        rec_v, ok_v;
    rtcp_rec_t   rec, ok_rec;

    always_comb
    begin
        len    = in_data.compound_length;
        co     = in_data.start_req ? '0 : co_reg;
        po     = in_data.start_req ? '0 : po_reg;
        ps     = in_data.start_req ? '0 : ps_reg;
        mode   = in_data.start_req ? MODE_HDR : mode_reg;
        blocks = in_data.start_req ? '0 : blocks_reg;
        aw     = in_data.start_req ? '0 : aw_reg;
        drop   = in_data.start_req ? 1'b0 : drop_reg;
        active = !drop && (co < len);
        aw_n   = {aw[23:0], in_data.data_byte};
        co_inc = co + 16'd1;

        co_next     = co;
        po_next     = po;
        ps_next     = ps;
        mode_next   = mode;
        count_next  = count_reg;
        blocks_next = blocks;
        phase_next  = phase_reg;
        aw_next     = aw;
        drop_next   = drop;
        ssrc_next   = ssrc_reg;
        ntp_next    = ntp_reg;
        hw_next     = hw_reg;

        pt        = aw_n[23:16];
        pkt_words = {1'b0, aw_n[15:0]} + 17'd1;
        pkt       = {pkt_words, 2'b00};
        pkt_start = co - 16'd3;
        pkt_end   = {4'b0, pkt_start} + {1'b0, pkt};
        new_mode  = MODE_SKIP;
        min_bytes = 10'(HDR_BYTES);
        fail      = 1'b0;
        fail_code = ST_OK;
        rec_v     = 1'b0;
        rec       = '0;
        ok_v      = 1'b0;
        ok_rec    = '0;

        if (pt == PT_SR)
        begin
            new_mode  = MODE_SR;
            min_bytes = 10'(SR_MIN_BYTES);
        end
        else if (pt == PT_RR)
        begin
            new_mode  = MODE_RR;
            min_bytes = 10'(RR_HDR_BYTES) + 10'(count_reg) * 10'(BLOCK_BYTES);
        end
        else if (pt == PT_RTPFB && count_reg == FMT_ONE)
        begin
            new_mode  = MODE_NACK;
            min_bytes = 10'(FB_MIN_BYTES);
        end
        else if (pt == PT_PSFB && count_reg == FMT_ONE)
        begin
            new_mode  = MODE_PLI;
            min_bytes = 10'(FB_MIN_BYTES);
        end

        if (active)
        begin
            aw_next = aw_n;
            if (mode == MODE_HDR)
            begin
                if (po == '0)
                begin
                    if ((len - co) < 16'(HDR_BYTES))
                    begin
                        fail      = 1'b1;
                        fail_code = ST_TRAILING;
                    end
                    else if (in_data.data_byte[7:6] != RTP_VERSION)
                    begin
                        fail      = 1'b1;
                        fail_code = ST_BAD_VER;
                    end
                    else
                    begin
                        count_next = in_data.data_byte[4:0];
                        po_next    = 16'd1;
                    end
                end
                else if (po < 16'd3)
                begin
                    po_next = po + 16'd1;
                end
                else if (pkt_end > {4'b0, len})
                begin
                    fail      = 1'b1;
                    fail_code = ST_OVERRUN;
                end
                else if (pkt < {9'b0, min_bytes})
                begin
                    fail      = 1'b1;
                    fail_code = ST_TOO_SHORT;
                end
                else
                begin
                    // pkt fits the compound here, so 16 bits hold it
                    ps_next     = pkt[15:0];
                    blocks_next = count_reg;
                    phase_next  = '0;
                    if (pkt == 19'(HDR_BYTES))
                    begin
                        mode_next = MODE_HDR;
                        po_next   = '0;
                    end
                    else
                    begin
                        mode_next = new_mode;
                        po_next   = 16'(HDR_BYTES);
                    end
                end
            end
            else
            begin
                case (mode)
                    MODE_SR:
                    begin
                        case (po)
                            16'd7:  ssrc_next = aw_n;
                            16'd11: ntp_next = {aw_n, 32'b0};
                            16'd15: ntp_next = {ntp_reg[63:32], aw_n};
                            16'd19: hw_next[0] = aw_n;
                            16'd23: hw_next[1] = aw_n;
                            16'd27:
                            begin
                                rec_v           = 1'b1;
                                rec.record_kind = KIND_SR;
                                rec.ssrc_a      = ssrc_reg;
                                rec.ntp_stamp   = ntp_reg;
                                rec.word_a      = hw_reg[0];
                                rec.word_b      = hw_reg[1];
                                rec.word_c      = aw_n;
                            end
                            default: ;
                        endcase
                    end
                    MODE_RR:
                    begin
                        if (po >= 16'd8)
                        begin
                            phase_next = (phase_reg == 5'(BLOCK_BYTES - 1)) ? 5'd0
                                                                           : phase_reg + 5'd1;
                        end
                        if (po == 16'd7)
                        begin
                            rec_v           = 1'b1;
                            rec.record_kind = KIND_RR_HDR;
                            rec.ssrc_a      = aw_n;
                        end
                        else if (po >= 16'd8 && blocks != '0)
                        begin
                            // phase is the byte position within the current report block
                            case (phase_reg)
                                5'd3:  ssrc_next = aw_n;
                                5'd7:  hw_next[0] = aw_n;
                                5'd11: hw_next[1] = aw_n;
                                5'd15: hw_next[2] = aw_n;
                                5'd19: hw_next[3] = aw_n;
                                5'd23:
                                begin
                                    rec_v           = 1'b1;
                                    rec.record_kind = KIND_RR_BLOCK;
                                    rec.ssrc_a      = ssrc_reg;
                                    rec.word_a      = hw_reg[1];
                                    rec.word_b      = hw_reg[2];
                                    rec.word_c      = hw_reg[3];
                                    rec.word_d      = aw_n;
                                    rec.frac_lost   = hw_reg[0][31:24];
                                    rec.cum_lost    = hw_reg[0][23:0];
                                    blocks_next     = blocks - 5'd1;
                                end
                                default: ;
                            endcase
                        end
                    end
                    MODE_NACK, MODE_PLI:
                    begin
                        if (po == 16'd7)
                        begin
                            ssrc_next = aw_n;
                        end
                        else if (po == 16'd11)
                        begin
                            rec_v           = 1'b1;
                            rec.record_kind = (mode == MODE_NACK) ? KIND_NACK_HDR : KIND_PLI;
                            rec.ssrc_a      = ssrc_reg;
                            rec.ssrc_b      = aw_n;
                        end
                        else if (mode == MODE_NACK && po >= 16'd12 && po[1:0] == 2'd3)
                        begin
                            rec_v           = 1'b1;
                            rec.record_kind = KIND_NACK_ITEM;
                            rec.word_a      = {16'b0, aw_n[31:16]};
                            rec.word_b      = {16'b0, aw_n[15:0]};
                        end
                    end
                    default: ;
                endcase

                if (({1'b0, po} + 17'd1) >= {1'b0, ps})
                begin
                    mode_next = MODE_HDR;
                    po_next   = '0;
                end
                else
                begin
                    po_next = po + 16'd1;
                end
            end

            if (fail)
            begin
                // an error stands alone and ends the compound
                rec_v           = 1'b1;
                rec             = '0;
                rec.record_kind = KIND_STATUS;
                rec.status      = fail_code;
                drop_next       = 1'b1;
            end
            else
            begin
                co_next = co_inc;
                if (co_inc == len)
                begin
                    ok_v      = 1'b1;
                    drop_next = 1'b1;
                end
            end
        end

        ok_rec.record_kind = KIND_STATUS;
        ok_rec.status      = ST_OK;
        ok_rec.last        = 1'b1;
        rec.last           = !ok_v;

        push.push0 = accept && (rec_v || ok_v);
        push.push1 = accept && rec_v && ok_v;
        push.rec0  = rec_v ? rec : ok_rec;
        push.rec1  = ok_rec;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            co_reg     <= '0;
            po_reg     <= '0;
            ps_reg     <= '0;
            mode_reg   <= MODE_HDR;
            count_reg  <= '0;
            blocks_reg <= '0;
            phase_reg  <= '0;
            aw_reg     <= '0;
            drop_reg   <= 1'b0;
        end
        else if (accept)
        begin
            co_reg     <= co_next;
            po_reg     <= po_next;
            ps_reg     <= ps_next;
            mode_reg   <= mode_next;
            count_reg  <= count_next;
            blocks_reg <= blocks_next;
            phase_reg  <= phase_next;
            aw_reg     <= aw_next;
            drop_reg   <= drop_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ssrc_reg <= '0;
            ntp_reg  <= '0;
            hw_reg   <= '{default: '0};
        end
        else if (accept)
        begin
            ssrc_reg <= ssrc_next;
            ntp_reg  <= ntp_next;
            hw_reg   <= hw_next;
        end
    end

    `RTCP_NEVER(a_pc_pair, clk, rst_n, push.push1 && !push.push0, "second record without first")
    `RTCP_ASSERT(a_pc_tail, clk, rst_n, push.push1 |-> !push.rec0.last, "first of pair marked last")
    `RTCP_NEVER(a_pc_ok, clk, rst_n, push.push1 && push.rec1.status != ST_OK, "pair tail not ok")
    `RTCP_NEVER(a_pc_end, clk, rst_n, drop_reg && !in_data.start_req && push.push0, "record after end")

endmodule

// ===== rtl/core/rtcp_compound_parser.sv =====
// ----------------------------------------------------------------------------
// RTCP compound parser
// Byte-serial RTCP compound packet walker with record output queue.
// ----------------------------------------------------------------------------
// Takes one byte of an RTCP compound packet per cycle while byte_ready is high
// and emits SR, RR header, report block, generic NACK header and entry, PLI
// and status records. Each byte yields zero, one or two records (two only
// when a record completes on the final byte, followed by the ok status).
// Records pass through a four-entry queue; byte_ready is high while at least
// two entries are free, so the byte side stalls whenever fewer are free.
// Records are registered in the queue before they reach rec_data.
// ----------------------------------------------------------------------------
module rtcp_compound_parser
    import rtcp_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      byte_valid,
    output logic      byte_ready,
    input  rtcp_in_t  byte_data,
    output logic      rec_valid,
    input  logic      rec_ready,
    output rtcp_rec_t rec_data
);

    rtcp_push_t push;
    logic       space_ok;

    assign byte_ready = space_ok;

    rtcp_parse_core u_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .accept  (byte_valid && space_ok),
        .in_data (byte_data),
        .push    (push)
    );

    rtcp_out_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .space_ok  (space_ok),
        .rec_valid (rec_valid),
        .rec_ready (rec_ready),
        .rec_data  (rec_data)
    );

endmodule
